// ----- hdl/pidpi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidpi_pkg
// Shared types, constants and fixed-point helpers for the PID controller.
// ----------------------------------------------------------------------------
package pidpi_pkg;

    localparam int SIG_W      = 32;
    localparam int GAIN_FRAC  = 8;
    localparam int ALPHA_FRAC = 16;
    localparam int OPA_W      = 18;
    localparam int PROD_W     = OPA_W + SIG_W;
    localparam int WIDE_W     = PROD_W + 1;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;

    typedef logic signed [SIG_W-1:0]  sig_t;
    typedef logic signed [OPA_W-1:0]  opa_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t SAT_MAX = 51'sd2147483647;
    localparam wide_t SAT_MIN = -51'sd2147483648;
    localparam opa_t  ALPHA_ONE = 18'sd65536;

    typedef enum logic [2:0] {
        REG_GAINS       = 3'd0,
        REG_OUT_BOUNDS  = 3'd1,
        REG_INT_BOUNDS  = 3'd2,
        REG_STEP_BOUNDS = 3'd3,
        REG_SMOOTHING   = 3'd4,
        REG_DEAD_ZONE   = 3'd5,
        REG_SEPARATION  = 3'd6,
        REG_MODE        = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [47:0] gains;
        logic [63:0] output_bounds;
        logic [63:0] integral_bounds;
        logic [63:0] step_bounds;
        logic [15:0] smoothing;
        logic [30:0] dead_zone;
        logic [30:0] separation_limit;
        logic [1:0]  mode_bits;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic mul_fa;
        logic mul_fb;
        logic filt;
        logic fin;
        logic clr;
    } cmd_t;

    typedef struct packed {
        logic out_blocked;
    } status_t;

    function automatic wide_t widen(input sig_t v);
        return {{(WIDE_W-SIG_W){v[SIG_W-1]}}, v};
    endfunction

    function automatic sig_t sat32(input wide_t v);
        sig_t r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[SIG_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[SIG_W-1:0];
        end else begin
            r = v[SIG_W-1:0];
        end
        return r;
    endfunction

    function automatic sig_t sub_sat(input sig_t a, input sig_t b);
        return sat32(widen(a) - widen(b));
    endfunction

    function automatic sig_t gain_scale(input prod_t p);
        prod_t s;
        s = p >>> GAIN_FRAC;
        return sat32({s[PROD_W-1], s});
    endfunction

    function automatic sig_t clamp_pair(input sig_t v, input logic [63:0] b);
        sig_t hi;
        sig_t lo;
        sig_t r;
        hi = $signed(b[63:32]);
        lo = $signed(b[31:0]);
        r  = (v > hi) ? hi : v;
        r  = (r < lo) ? lo : r;
        return r;
    endfunction

    function automatic logic [SIG_W-1:0] magnitude(input sig_t v);
        return v[SIG_W-1] ? (~v + 32'd1) : v;
    endfunction

endpackage

// ----- hdl/pidpi_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidpi_regs
// APB-style configuration register file for the PID controller.
// ----------------------------------------------------------------------------
module pidpi_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pidpi_pkg::ADDR_W-1:0]   paddr,
    input  logic [pidpi_pkg::DATA_W-1:0]   pwdata,
    output logic [pidpi_pkg::DATA_W-1:0]   prdata,
    output pidpi_pkg::cfg_t                cfg
);
    import pidpi_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_GAINS:       cfg_next.gains            = pwdata[47:0];
                REG_OUT_BOUNDS:  cfg_next.output_bounds    = pwdata;
                REG_INT_BOUNDS:  cfg_next.integral_bounds  = pwdata;
                REG_STEP_BOUNDS: cfg_next.step_bounds      = pwdata;
                REG_SMOOTHING:   cfg_next.smoothing        = pwdata[15:0];
                REG_DEAD_ZONE:   cfg_next.dead_zone        = pwdata[30:0];
                REG_SEPARATION:  cfg_next.separation_limit = pwdata[30:0];
                REG_MODE:        cfg_next.mode_bits        = pwdata[1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GAINS:       prdata = {16'd0, cfg_reg.gains};
            REG_OUT_BOUNDS:  prdata = cfg_reg.output_bounds;
            REG_INT_BOUNDS:  prdata = cfg_reg.integral_bounds;
            REG_STEP_BOUNDS: prdata = cfg_reg.step_bounds;
            REG_SMOOTHING:   prdata = {48'd0, cfg_reg.smoothing};
            REG_DEAD_ZONE:   prdata = {33'd0, cfg_reg.dead_zone};
            REG_SEPARATION:  prdata = {33'd0, cfg_reg.separation_limit};
            REG_MODE:        prdata = {62'd0, cfg_reg.mode_bits};
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/pidpi_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidpi_ctrl
// Sequencer that steps the shared multiplier datapath through one sample.
// ----------------------------------------------------------------------------
module pidpi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               action,
    output logic               in_stall,
    input  pidpi_pkg::status_t status,
    output pidpi_pkg::cmd_t    cmd
);
    import pidpi_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_PREP   = 10'b00_0000_0010,
        ST_MUL_P  = 10'b00_0000_0100,
        ST_MUL_I  = 10'b00_0000_1000,
        ST_MUL_D  = 10'b00_0001_0000,
        ST_MUL_FA = 10'b00_0010_0000,
        ST_MUL_FB = 10'b00_0100_0000,
        ST_FILT   = 10'b00_1000_0000,
        ST_FIN    = 10'b01_0000_0000,
        ST_CLR    = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = action ? ST_CLR : ST_PREP;
                end
            end
            ST_PREP:   state_next = ST_MUL_P;
            ST_MUL_P:  state_next = ST_MUL_I;
            ST_MUL_I:  state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_MUL_FA;
            ST_MUL_FA: state_next = ST_MUL_FB;
            ST_MUL_FB: state_next = ST_FILT;
            ST_FILT:   state_next = ST_FIN;
            ST_FIN, ST_CLR:
            begin
                if (!status.out_blocked)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign cmd.load_in = (state_reg == ST_IDLE) && in_valid;
    assign cmd.prep    = (state_reg == ST_PREP);
    assign cmd.mul_p   = (state_reg == ST_MUL_P);
    assign cmd.mul_i   = (state_reg == ST_MUL_I);
    assign cmd.mul_d   = (state_reg == ST_MUL_D);
    assign cmd.mul_fa  = (state_reg == ST_MUL_FA);
    assign cmd.mul_fb  = (state_reg == ST_MUL_FB);
    assign cmd.filt    = (state_reg == ST_FILT);
    assign cmd.fin     = (state_reg == ST_FIN);
    assign cmd.clr     = (state_reg == ST_CLR);

`ifndef ASSERT_OFF
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_PREP || state_reg == ST_CLR)
        else $error("accepted beat did not start a sequence");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN && status.out_blocked |=> state_reg == ST_FIN)
        else $error("result step left while output was blocked");
`endif

endmodule

// ----- hdl/pidpi_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidpi_dp
// PID datapath: error terms, one shared 18x32 multiplier, filter, clamps,
// controller history and the output register.
// ----------------------------------------------------------------------------
module pidpi_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  pidpi_pkg::cfg_t    cfg,
    input  pidpi_pkg::cmd_t    cmd,
    output pidpi_pkg::status_t status,
    input  pidpi_pkg::sig_t    target,
    input  pidpi_pkg::sig_t    measurement,
    output logic               out_valid,
    input  logic               out_stall,
    output pidpi_pkg::sig_t    drive
);
    import pidpi_pkg::*;

    sig_t  tgt_reg, meas_reg;
    sig_t  errdz_reg, dstep_reg, dd_reg;
    logic  integ_ok_reg;
    prod_t prod_reg, acc_reg;
    sig_t  tp_reg, ti_reg, td_reg, icand_reg, filt_reg, inc_reg;
    sig_t  drive_reg;
    logic  out_valid_reg;
    sig_t  last_err_reg, last_step_reg, last_meas_reg;
    sig_t  integ_reg, prev_reg, fd_reg;

    logic  pos;
    logic  commit;
    opa_t  opa;
    sig_t  opb;
    sig_t  err, delta, errdz;
    logic [SIG_W-1:0] err_mag;
    logic  small_err;
    wide_t filt_sum;
    sig_t  integ_new, drive_raw, drive_new;
    opa_t  kp, ki, kd;

    assign pos = !cfg.mode_bits[0];
    assign kp  = opa_t'($signed(cfg.gains[15:0]));
    assign ki  = opa_t'($signed(cfg.gains[31:16]));
    assign kd  = opa_t'($signed(cfg.gains[47:32]));

    assign status.out_blocked = out_valid_reg && out_stall;
    assign commit = (cmd.fin || cmd.clr) && !status.out_blocked;

    assign err       = sub_sat(tgt_reg, meas_reg);
    assign delta     = sub_sat(err, last_err_reg);
    assign err_mag   = magnitude(err);
    assign small_err = err_mag < {1'b0, cfg.dead_zone};
    assign errdz     = small_err ? '0 : err;

    always_comb
    begin
        opa = kp;
        opb = errdz_reg;
        priority if (cmd.mul_p)
        begin
            opa = kp;
            opb = pos ? errdz_reg : dstep_reg;
        end
        else if (cmd.mul_i)
        begin
            opa = ki;
            opb = errdz_reg;
        end
        else if (cmd.mul_d)
        begin
            opa = kd;
            opb = pos ? dstep_reg : dd_reg;
        end
        else if (cmd.mul_fa)
        begin
            opa = opa_t'({2'b00, cfg.smoothing});
            opb = fd_reg;
        end
        else if (cmd.mul_fb)
        begin
            opa = ALPHA_ONE - opa_t'({2'b00, cfg.smoothing});
            opb = td_reg;
        end
    end

    assign filt_sum  = $signed({acc_reg[PROD_W-1], acc_reg} + {prod_reg[PROD_W-1], prod_reg})
                       >>> ALPHA_FRAC;
    assign integ_new = integ_ok_reg ? icand_reg : integ_reg;
    assign drive_raw = pos ? sat32(widen(tp_reg) + widen(integ_new) + widen(filt_reg))
                           : sat32(widen(prev_reg) + widen(inc_reg));
    assign drive_new = clamp_pair(drive_raw, cfg.output_bounds);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            tgt_reg  <= target;
            meas_reg <= measurement;
        end
        if (cmd.prep)
        begin
            errdz_reg    <= errdz;
            dstep_reg    <= (pos && cfg.mode_bits[1]) ? sub_sat(last_meas_reg, meas_reg)
                                                      : delta;
            integ_ok_reg <= (cfg.separation_limit == '0) || small_err ||
                            (err_mag <= {1'b0, cfg.separation_limit});
        end
        if (cmd.mul_p)
        begin
            dd_reg <= sub_sat(dstep_reg, last_step_reg);
        end
        if (cmd.mul_p || cmd.mul_i || cmd.mul_d || cmd.mul_fa || cmd.mul_fb)
        begin
            prod_reg <= prod_t'(opa) * prod_t'(opb);
        end
        if (cmd.mul_i)
        begin
            tp_reg <= gain_scale(prod_reg);
        end
        if (cmd.mul_d)
        begin
            ti_reg <= gain_scale(prod_reg);
        end
        if (cmd.mul_fa)
        begin
            td_reg    <= gain_scale(prod_reg);
            icand_reg <= clamp_pair(sat32(widen(integ_reg) + widen(ti_reg)),
                                    cfg.integral_bounds);
        end
        if (cmd.mul_fb)
        begin
            acc_reg <= prod_reg;
        end
        if (cmd.filt)
        begin
            filt_reg <= sat32(filt_sum);
            inc_reg  <= clamp_pair(sat32(widen(tp_reg) + widen(ti_reg) + widen(td_reg)),
                                   cfg.step_bounds);
        end
        if (commit)
        begin
            drive_reg <= cmd.clr ? '0 : drive_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_err_reg  <= '0;
            last_step_reg <= '0;
            last_meas_reg <= '0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            fd_reg        <= '0;
        end
        else
        begin
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit && cmd.clr)
            begin
                last_err_reg  <= '0;
                last_step_reg <= '0;
                last_meas_reg <= '0;
                integ_reg     <= '0;
                prev_reg      <= '0;
                fd_reg        <= '0;
            end
            else if (commit)
            begin
                last_err_reg  <= errdz_reg;
                last_step_reg <= dstep_reg;
                last_meas_reg <= meas_reg;
                prev_reg      <= drive_new;
                fd_reg        <= pos ? filt_reg : td_reg;
                if (pos)
                begin
                    integ_reg <= integ_new;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> !(out_valid_reg && out_stall))
        else $error("result overwrote a beat that was still waiting");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        commit && cmd.clr |=> drive_reg == '0 && integ_reg == '0 && prev_reg == '0)
        else $error("clear left history or drive nonzero");

    a_drive_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        commit && cmd.fin &&
        $signed(cfg.output_bounds[31:0]) <= $signed(cfg.output_bounds[63:32])
        |=> drive_reg <= $signed($past(cfg.output_bounds[63:32])) &&
            drive_reg >= $signed($past(cfg.output_bounds[31:0])))
        else $error("drive outside output bounds");

    a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> prev_reg == drive_reg)
        else $error("previous drive differs from delivered drive");
`endif

endmodule

// ----- hdl/pid_position_incremental.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_incremental
// Positional and incremental fixed-point PID controller with APB set-up.
// ----------------------------------------------------------------------------
// Sequence: a compute beat passes the prep, P, I, D, FA, FB, filter and finish
// states, a clear beat the clear state; each waits in its last state while the
// output is blocked. A beat is taken only in idle; five products share one
// 18x32 multiplier in sequence. Reset: rst_n idles the sequencer and zeroes
// configuration, output valid and history; other registers are not reset.
// ----------------------------------------------------------------------------
module pid_position_incremental (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pidpi_pkg::ADDR_W-1:0] paddr,
    input  logic [pidpi_pkg::DATA_W-1:0] pwdata,
    output logic [pidpi_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic signed [31:0]           target,
    input  logic signed [31:0]           measurement,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [31:0]           drive
);
    import pidpi_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    assign pready = 1'b1;

    pidpi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    pidpi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pidpi_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .target      (target),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive)
    );

endmodule
